FILE: rtl/core/smsd_pkg.sv
// Shared constants, types and helpers for the sliding median spike detector.
`timescale 1ns / 1ps

package smsd_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 7;
    localparam int COUNT_W         = 32;
    localparam logic [CFG_W-1:0] CFG_RESET_LEN = 7'd5;

    // Broadcast control from the top level to every cell of the sorted chain.
    typedef struct packed {
        logic load;       // an item transfer updates the chain this cycle
        logic remove_en;  // the window is full, so the oldest sample leaves
    } cell_ctrl_t;

    // Length zero acts as one, and lengths above the window depth are clipped.
    function automatic int len_clamp(input logic [CFG_W-1:0] wl, input int wmax);
        int len;
        len = int'(wl);
        if (len == 0) begin
            len = 1;
        end
        if (len > wmax) begin
            len = wmax;
        end
        return len;
    endfunction

endpackage

FILE: rtl/core/smsd_cell.sv
// One cell of the sorted window chain, with its tap of the arrival shift line.
`timescale 1ns / 1ps

module smsd_cell #(
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF,
    parameter int LEN_W       = 7,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  smsd_pkg::cell_ctrl_t   ctrl,
    input  logic [SAMPLE_BITS-1:0] new_sample,
    input  logic [SAMPLE_BITS-1:0] oldest,
    input  logic [LEN_W-1:0]       w_count,
    input  logic [SAMPLE_BITS-1:0] right_v,
    input  logic [SAMPLE_BITS-1:0] left_w,
    input  logic                   left_gt,
    input  logic [SAMPLE_BITS-1:0] left_a,
    output logic [SAMPLE_BITS-1:0] v,
    output logic [SAMPLE_BITS-1:0] w,
    output logic                   gt,
    output logic [SAMPLE_BITS-1:0] a
);
    import smsd_pkg::*;

    logic [SAMPLE_BITS-1:0] v_reg;
    logic [SAMPLE_BITS-1:0] v_next;
    logic [SAMPLE_BITS-1:0] a_reg;
    logic                   removed;
    logic                   w_valid;

    // The window is sorted, so the first entry not below the oldest sample is
    // the one that leaves; every cell from there on takes its right neighbor.
    assign removed = ctrl.remove_en && (v_reg >= oldest);
    assign w       = removed ? right_v : v_reg;
    assign w_valid = LEN_W'(INDEX) < w_count;
    assign gt      = !w_valid || (w > new_sample);

    // Insertion after equal values: cells past the slot shift right by one.
    always_comb
    begin
        if (left_gt) begin
            v_next = left_w;
        end else if (gt) begin
            v_next = new_sample;
        end else begin
            v_next = w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            v_reg <= v_next;
            a_reg <= left_a;
        end
    end

    assign v = v_reg;
    assign a = a_reg;

endmodule

FILE: rtl/core/sliding_median_spike_detector.sv
// Top level of the sliding median spike detector: control, threshold and result register.
`timescale 1ns / 1ps

// The detector takes one sample per clock and returns one result per sample, in
// the cycle after the input transfer, through a result register. A row of
// WINDOW_MAX cells keeps the window sorted: in the same cycle each cell drops the
// oldest sample and makes room for the new one using its neighbors' values, while
// a parallel shift line of taps tracks arrival order. The sustained rate is one
// item per cycle; it is held back only while the result register waits on
// result_stall. The first len_reg samples after reset or after a write of
// window_length only fill the window (window_full low). The threshold is the sum
// of the two middle entries, or twice the middle entry for an odd length, and a
// sample at or above it raises alert and bumps a saturating 32-bit count. No
// clearing pass is needed after reset. Write window_length only while idle.
module sliding_median_spike_detector #(
    parameter int WINDOW_MAX  = smsd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smsd_pkg::CFG_W-1:0]    window_length,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          window_full,
    output logic                          alert,
    output logic [smsd_pkg::COUNT_W-1:0]  alert_count
);
    import smsd_pkg::*;

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int RST_LEN  = len_clamp(CFG_RESET_LEN, WINDOW_MAX);
    localparam int RST_MID  = RST_LEN / 2;
    localparam int RST_LO   = (RST_LEN % 2 == 1) ? RST_MID : RST_MID - 1;
    localparam int RST_LAST = RST_LEN - 1;

    logic [LEN_W-1:0]   len_reg;
    logic [IDX_W-1:0]   mid_idx_reg;
    logic [IDX_W-1:0]   lo_idx_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic [LEN_W-1:0]   filled_reg;
    logic [LEN_W-1:0]   filled_next;
    logic [COUNT_W-1:0] alert_total_reg;
    logic [COUNT_W-1:0] alert_total_next;
    logic               result_valid_reg;
    logic               window_full_reg;
    logic               alert_reg;

    logic [LEN_W-1:0]   len_next;
    logic [LEN_W-1:0]   mid_len;
    logic               accept;
    logic               cfg_write;
    logic               full;
    logic               hit;
    logic [LEN_W-1:0]   w_count;
    logic [SAMPLE_BITS:0] threshold;
    logic [SAMPLE_BITS-1:0] oldest;
    cell_ctrl_t         ctrl;

    logic [SAMPLE_BITS-1:0] v_all [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] w_all [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] a_all [WINDOW_MAX];
    logic                   gt_all [WINDOW_MAX];

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign sample_stall = result_valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;

    assign len_next = LEN_W'(len_clamp(window_length, WINDOW_MAX));
    assign mid_len  = len_next >> 1;

    assign full    = (filled_reg == len_reg);
    assign w_count = full ? (len_reg - LEN_W'(1)) : filled_reg;
    assign oldest  = a_all[last_idx_reg];

    assign ctrl.load      = accept;
    assign ctrl.remove_en = full;

    // For an odd length both indexes point at the middle entry.
    assign threshold = {1'b0, v_all[mid_idx_reg]} + {1'b0, v_all[lo_idx_reg]};
    assign hit       = full && ({1'b0, sample} >= threshold);

    always_comb
    begin
        filled_next      = filled_reg;
        alert_total_next = alert_total_reg;
        if (cfg_write) begin
            filled_next = '0;
        end else if (accept) begin
            if (!full) begin
                filled_next = filled_reg + LEN_W'(1);
            end
            if (hit && (alert_total_reg != {COUNT_W{1'b1}})) begin
                alert_total_next = alert_total_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg          <= LEN_W'(RST_LEN);
            mid_idx_reg      <= IDX_W'(RST_MID);
            lo_idx_reg       <= IDX_W'(RST_LO);
            last_idx_reg     <= IDX_W'(RST_LAST);
            filled_reg       <= '0;
            alert_total_reg  <= '0;
            result_valid_reg <= 1'b0;
            window_full_reg  <= 1'b0;
            alert_reg        <= 1'b0;
        end else begin
            filled_reg      <= filled_next;
            alert_total_reg <= alert_total_next;
            if (cfg_write) begin
                len_reg      <= len_next;
                mid_idx_reg  <= IDX_W'(mid_len);
                lo_idx_reg   <= len_next[0] ? IDX_W'(mid_len) : IDX_W'(mid_len - LEN_W'(1));
                last_idx_reg <= IDX_W'(len_next - LEN_W'(1));
            end
            if (accept) begin
                result_valid_reg <= 1'b1;
                window_full_reg  <= full;
                alert_reg        <= hit;
            end else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic [SAMPLE_BITS-1:0] right_v;
        logic [SAMPLE_BITS-1:0] left_w;
        logic                   left_gt;
        logic [SAMPLE_BITS-1:0] left_a;

        if (i == 0) begin : g_first
            assign left_w  = '0;
            assign left_gt = 1'b0;
            assign left_a  = sample;
        end else begin : g_inner
            assign left_w  = w_all[i-1];
            assign left_gt = gt_all[i-1];
            assign left_a  = a_all[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_body
            assign right_v = v_all[i+1];
        end

        smsd_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LEN_W       (LEN_W),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_sample (sample),
            .oldest     (oldest),
            .w_count    (w_count),
            .right_v    (right_v),
            .left_w     (left_w),
            .left_gt    (left_gt),
            .left_a     (left_a),
            .v          (v_all[i]),
            .w          (w_all[i]),
            .gt         (gt_all[i]),
            .a          (a_all[i])
        );
    end

    assign result_valid = result_valid_reg;
    assign window_full  = window_full_reg;
    assign alert        = alert_reg;
    assign alert_count  = alert_total_reg;

`ifndef NO_ASSERTIONS
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= len_reg)
        else $error("fill count exceeds window length");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full |=> window_full_reg)
        else $error("full window not reported on result");

    a_alert_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && alert_reg |-> window_full_reg)
        else $error("alert raised before window filled");

    a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        alert_total_reg >= $past(alert_total_reg))
        else $error("alert count decreased");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid_reg)
        else $error("input stalled with empty result register");
`endif

endmodule

FILE: tb/sv/sliding_median_spike_detector_test.sv
// Self-checking testbench for the sliding median spike detector.
`timescale 1ns / 1ps

module sliding_median_spike_detector_test;

    import smsd_pkg::*;

    localparam int DEPTH = WINDOW_MAX_DEF;
    localparam int SW    = SAMPLE_BITS_DEF;

    typedef struct {
        logic               full;
        logic               alert;
        logic [COUNT_W-1:0] count;
    } spike_report_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   window_length = CFG_RESET_LEN;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    logic [SW-1:0]      sample = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               window_full;
    logic               alert;
    logic [COUNT_W-1:0] alert_count;

    // Idle and stall injection is turned off while this is set.
    logic quiet = 1'b0;

    logic [SW-1:0]  samples_to_send[$];
    spike_report_t  spike_reports[$];

    // Mirror of the detector state.
    logic [CFG_W-1:0]   median_len_cfg = CFG_RESET_LEN;
    logic [SW-1:0]      arrival[DEPTH];
    int                 arrival_fill = 0;
    int                 arrival_head = 0;
    logic [COUNT_W-1:0] spike_total = '0;

    int mismatch_count = 0;
    int samples_sent = 0;
    int medians_compared = 0;
    int spikes_predicted = 0;
    int length_writes = 0;

    sliding_median_spike_detector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_length(window_length),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_full  (window_full),
        .alert        (alert),
        .alert_count  (alert_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Works out the report for one accepted sample and advances the mirror.
    function automatic void predict_spike(input logic [SW-1:0] s);
        spike_report_t rep;
        logic [SW-1:0] ordered[DEPTH];
        logic [SW-1:0] key;
        logic [SW:0]   threshold;
        int            len;
        int            i;
        int            k;
        len = (median_len_cfg == 0) ? 1 :
              ((int'(median_len_cfg) > DEPTH) ? DEPTH : int'(median_len_cfg));
        rep.full  = 1'b0;
        rep.alert = 1'b0;
        if (arrival_fill < len)
        begin
            arrival[arrival_fill] = s;
            arrival_fill++;
        end
        else
        begin
            for (i = 0; i < len; i++)
            begin
                key = arrival[i];
                k = i;
                while (k > 0 && ordered[k-1] > key)
                begin
                    ordered[k] = ordered[k-1];
                    k--;
                end
                ordered[k] = key;
            end
            // An even length compares against the sum of both middle entries.
            if (len % 2 == 1)
                threshold = {ordered[len/2], 1'b0};
            else
                threshold = {1'b0, ordered[len/2-1]} + {1'b0, ordered[len/2]};
            rep.full = 1'b1;
            medians_compared++;
            if ({1'b0, s} >= threshold)
            begin
                rep.alert = 1'b1;
                spikes_predicted++;
                if (spike_total != '1)
                    spike_total++;
            end
            arrival[arrival_head] = s;
            arrival_head = (arrival_head + 1 >= len) ? 0 : arrival_head + 1;
        end
        rep.count = spike_total;
        spike_reports.insert(spike_reports.size(), rep);
        samples_sent++;
    endfunction

    // Sample driver: holds each sample until its transfer, then loads the next one.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        logic holding;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            holding = sample_valid;
            if (sample_valid && !sample_stall)
            begin
                predict_spike(sample);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (samples_to_send.size() > 0 && (quiet || $urandom_range(99) >= 6))
                begin
                    sample_valid <= 1'b1;
                    sample <= samples_to_send.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= !quiet && ($urandom_range(99) < 6);
    end

    always @(posedge clk)
    begin : report_monitor
        spike_report_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (spike_reports.size() == 0)
            begin
                $error("result transfer with no report outstanding");
                mismatch_count++;
            end
            else
            begin
                due = spike_reports.pop_front();
                if (window_full !== due.full)
                begin
                    $error("window_full: expected %0d, actual %0d", due.full, window_full);
                    mismatch_count++;
                end
                if (alert !== due.alert)
                begin
                    $error("alert: expected %0d, actual %0d", due.alert, alert);
                    mismatch_count++;
                end
                if (alert_count !== due.count)
                begin
                    $error("alert_count: expected %0d, actual %0d", due.count, alert_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Checks on the falling edge, when every update of the rising edge has settled.
    task automatic drain_reports();
        while (samples_to_send.size() != 0 || sample_valid || spike_reports.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes window_length once the detector is idle; this empties the window.
    task automatic write_window_length(input logic [CFG_W-1:0] len);
        drain_reports();
        cfg_valid <= 1'b1;
        window_length <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        median_len_cfg = len;
        arrival_fill = 0;
        arrival_head = 0;
        length_writes++;
    endtask

    // Samples cluster around a per-phase level, with spikes near twice that level and some random or extreme values.
    function automatic logic [SW-1:0] pick_sample(input int level);
        int roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 75)
            v = level + $urandom_range(level / 8 + 3);
        else if (roll < 90)
            v = 2 * (level + $urandom_range(level / 8 + 3));
        else if (roll < 96)
            v = $urandom_range(65535);
        else
            v = ($urandom_range(1) == 1) ? 65535 : 0;
        if (v > 65535)
            v = 65535;
        return v[SW-1:0];
    endfunction

    initial
    begin
        int phase_lengths[$] = '{64, 127, 1, 0, 3, 2, 4, 65, 6, 7, 9, 16, 33, 5};
        int random_items;
        int phase;
        int len_sel;
        int eff;
        int n;
        int level;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset length of five: inclusive threshold, a near miss, both sample extremes.
        samples_to_send = '{10, 20, 30, 40, 50, 60, 79, 65535, 0};
        drain_reports();
        // Length zero acts as one; a zero median makes any sample a spike.
        write_window_length(7'd0);
        samples_to_send = '{0, 0, 65535, 32768, 65535};
        drain_reports();
        // Even length uses the sum of the two middle entries.
        write_window_length(7'd2);
        samples_to_send = '{100, 200, 300, 499};
        drain_reports();
        // Repeated values in the window.
        write_window_length(7'd3);
        samples_to_send = '{7, 7, 7, 14, 13};

        random_items = 0;
        phase = 0;
        while (random_items < 1130)
        begin
            if (phase < phase_lengths.size())
                len_sel = phase_lengths[phase];
            else
                len_sel = $urandom_range(12, 1);
            write_window_length(len_sel[CFG_W-1:0]);
            // One phase of a full 64 deep window runs with no idles or stalls.
            quiet = (len_sel == 127);
            eff = (len_sel == 0) ? 1 : ((len_sel > DEPTH) ? DEPTH : len_sel);
            n = eff + $urandom_range(70, 30);
            level = ($urandom_range(2) == 0) ? $urandom_range(6) : $urandom_range(30000);
            repeat (n) samples_to_send.insert(samples_to_send.size(), pick_sample(level));
            random_items += n;
            phase++;
            drain_reports();
            quiet = 1'b0;
        end

        drain_reports();
        repeat (4) @(posedge clk);
        $display("Sent %0d samples across %0d window length settings.",
                 samples_sent, length_writes + 1);
        $display("%0d samples were compared against the median and %0d were spikes.",
                 medians_compared, spikes_predicted);
        if (mismatch_count == 0)
            $display("[sliding_median_spike_detector] OK");
        else
            $display("[sliding_median_spike_detector] ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[sliding_median_spike_detector] ERROR");
        $finish;
    end

endmodule
